FILE: hw/rtl/fvn_pkg.sv
package fvn_pkg;

  localparam int unsigned POINT_W   = 40;
  localparam int unsigned OCT_W     = 4;
  localparam int unsigned NOISE_W   = 16;
  localparam int unsigned SEED_W    = 32;

  localparam int unsigned DEF_MAX_OCTAVES = 8;
  localparam int unsigned DEF_FRAC_BITS   = 16;

  localparam int unsigned RECIP_W     = 25;
  localparam int unsigned RECIP_SHIFT = 24;
  localparam int unsigned RECIP_DEPTH = 17;

  // Rounded 2^24 / (2^n - 1) for n = 1 to 16; entry 0 repeats entry 1.
  localparam logic [RECIP_W-1:0] RECIP_TAB [RECIP_DEPTH] = '{
    25'd16777216, 25'd16777216, 25'd5592405, 25'd2396745, 25'd1118481,
    25'd541201, 25'd266305, 25'd132104, 25'd65793, 25'd32832,
    25'd16400, 25'd8196, 25'd4097, 25'd2048, 25'd1024,
    25'd512, 25'd256
  };

endpackage

FILE: hw/rtl/fvn_intf.sv
interface fvn_in_if;
  import fvn_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [POINT_W-1:0]  point_x;
  logic signed [POINT_W-1:0]  point_y;
  logic        [OCT_W-1:0]    octave_count;

  modport source (output valid, output point_x, output point_y, output octave_count,
                  input ready);
  modport sink (input valid, input point_x, input point_y, input octave_count,
                output ready);
endinterface

interface fvn_out_if;
  import fvn_pkg::*;

  logic               valid;
  logic               ready;
  logic [NOISE_W-1:0] noise_value;

  modport source (output valid, output noise_value, input ready);
  modport sink (input valid, input noise_value, output ready);
endinterface

interface fvn_cfg_if;
  import fvn_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [SEED_W-1:0] seed;

  modport source (output valid, output seed, input ready);
  modport sink (input valid, input seed, output ready);
endinterface

FILE: hw/rtl/fractal_value_noise_2d.sv
// Fractal 2D value noise. Each accepted beat returns one noise beat summed over
// n octaves, where n is the octave count after clamping to the range 1 to
// MAX_OCTAVES. A new beat is accepted only in the idle state, once the last
// result is in the output register. All products come from a single
// 32 by 32 bit multiplier that serves smoothstep, the four corner hashes, the
// three interpolations and the final normalisation in turn. A finished result
// waits in the output register while the next beat is accepted. The seed may
// be written at any time the block is idle.
module fractal_value_noise_2d #(
  parameter int unsigned MAX_OCTAVES = fvn_pkg::DEF_MAX_OCTAVES,
  parameter int unsigned FRAC_BITS   = fvn_pkg::DEF_FRAC_BITS
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  fvn_cfg_if.sink   cfg_i,
  fvn_in_if.sink    in_i,
  fvn_out_if.source out_o
);
  import fvn_pkg::*;

  localparam int unsigned SX_W  = FRAC_BITS + 32;
  localparam int unsigned NW    = $clog2(MAX_OCTAVES + 1);
  localparam int unsigned ACC_W = 16 + MAX_OCTAVES;

  localparam logic [31:0] HASH_MUL_X   = 32'd374761393;
  localparam logic [31:0] HASH_MUL_Y   = 32'd668265263;
  localparam logic [31:0] HASH_MUL_MIX = 32'd1274126177;
  localparam logic [17:0] SMOOTH_K     = 18'd196608;
  localparam logic [16:0] ONE_Q16      = 17'd65536;

  typedef enum logic [18:0] {
    ST_IDLE = 19'h00001,
    ST_SMX0 = 19'h00002,
    ST_SMX1 = 19'h00004,
    ST_SMY0 = 19'h00008,
    ST_SMY1 = 19'h00010,
    ST_HA   = 19'h00020,
    ST_HB   = 19'h00040,
    ST_HC   = 19'h00080,
    ST_HD   = 19'h00100,
    ST_L0   = 19'h00200,
    ST_L1   = 19'h00400,
    ST_L2   = 19'h00800,
    ST_L3   = 19'h01000,
    ST_L4   = 19'h02000,
    ST_L5   = 19'h04000,
    ST_L6   = 19'h08000,
    ST_L7   = 19'h10000,
    ST_N0   = 19'h20000,
    ST_N1   = 19'h40000
  } state_e;

  state_e             state_q, state_d;
  logic [SEED_W-1:0]  seed_q;
  logic               out_valid_q, out_valid_d;
  logic [NOISE_W-1:0] out_data_q, out_data_d;

  logic [SX_W-1:0]    sx_q, sx_d, sy_q, sy_d;
  logic [NW-1:0]      n_q, n_d, oct_q, oct_d;
  logic [1:0]         c_q, c_d;
  logic [ACC_W-1:0]   acc_q, acc_d;
  logic [15:0]        fx_q, fx_d, fy_q, fy_d;
  logic [31:0]        hash_q, hash_d, lsum_q, lsum_d;
  logic [15:0]        row0_q, row0_d, row1_q, row1_d, vo_q, vo_d;
  logic [15:0]        corner_q [4];
  logic [15:0]        corner_d [4];
  logic [63:0]        prod_q, prod_d;

  logic               mul_en;
  logic [31:0]        mul_a, mul_b;
  logic [15:0]        fqx, fqy;
  logic [31:0]        ix, iy, cx, cy;
  logic [31:0]        hsum, hmix, lerp_sum;
  logic [15:0]        cval;
  logic [16:0]        inv_fx, inv_fy;
  logic [17:0]        smb_x, smb_y;
  logic [NW-1:0]      n_in;

  generate
    if (FRAC_BITS >= 16) begin : g_frac_trunc
      assign fqx = sx_q[FRAC_BITS-1 -: 16];
      assign fqy = sy_q[FRAC_BITS-1 -: 16];
    end else begin : g_frac_pad
      assign fqx = 16'(sx_q[FRAC_BITS-1:0]) << (16 - FRAC_BITS);
      assign fqy = 16'(sy_q[FRAC_BITS-1:0]) << (16 - FRAC_BITS);
    end
  endgenerate

  assign ix       = sx_q[FRAC_BITS +: 32];
  assign iy       = sy_q[FRAC_BITS +: 32];
  assign cx       = ix + 32'(c_q[0]);
  assign cy       = iy + 32'(c_q[1]);
  assign smb_x    = SMOOTH_K - {1'b0, fqx, 1'b0};
  assign smb_y    = SMOOTH_K - {1'b0, fqy, 1'b0};
  assign inv_fx   = ONE_Q16 - 17'(fx_q);
  assign inv_fy   = ONE_Q16 - 17'(fy_q);
  assign hsum     = hash_q + prod_q[31:0];
  assign hmix     = prod_q[31:0] ^ 32'($signed(prod_q[31:0]) >>> 16);
  assign cval     = hmix[30:15];
  assign lerp_sum = lsum_q + prod_q[31:0];

  always_comb begin
    if (int'(in_i.octave_count) == 0) begin
      n_in = NW'(1);
    end else if (int'(in_i.octave_count) > int'(MAX_OCTAVES)) begin
      n_in = NW'(MAX_OCTAVES);
    end else begin
      n_in = NW'(in_i.octave_count);
    end
  end

  assign cfg_i.ready       = 1'b1;
  assign in_i.ready        = (state_q == ST_IDLE);
  assign out_o.valid       = out_valid_q;
  assign out_o.noise_value = out_data_q;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    sx_d        = sx_q;
    sy_d        = sy_q;
    n_d         = n_q;
    oct_d       = oct_q;
    c_d         = c_q;
    acc_d       = acc_q;
    fx_d        = fx_q;
    fy_d        = fy_q;
    hash_d      = hash_q;
    lsum_d      = lsum_q;
    row0_d      = row0_q;
    row1_d      = row1_q;
    vo_d        = vo_q;
    corner_d    = corner_q;
    mul_en      = 1'b0;
    mul_a       = '0;
    mul_b       = '0;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          sx_d    = SX_W'($signed(in_i.point_x));
          sy_d    = SX_W'($signed(in_i.point_y));
          n_d     = n_in;
          oct_d   = '0;
          c_d     = '0;
          acc_d   = '0;
          state_d = ST_SMX0;
        end
      end
      ST_SMX0: begin
        mul_en  = 1'b1;
        mul_a   = 32'(fqx);
        mul_b   = 32'(fqx);
        state_d = ST_SMX1;
      end
      ST_SMX1: begin
        mul_en  = 1'b1;
        mul_a   = prod_q[31:0];
        mul_b   = 32'(smb_x);
        state_d = ST_SMY0;
      end
      ST_SMY0: begin
        fx_d    = prod_q[47:32];
        mul_en  = 1'b1;
        mul_a   = 32'(fqy);
        mul_b   = 32'(fqy);
        state_d = ST_SMY1;
      end
      ST_SMY1: begin
        mul_en  = 1'b1;
        mul_a   = prod_q[31:0];
        mul_b   = 32'(smb_y);
        state_d = ST_HA;
      end
      ST_HA: begin
        if (c_q == 2'd0) begin
          fy_d = prod_q[47:32];
        end else begin
          corner_d[c_q - 2'd1] = cval;
        end
        mul_en  = 1'b1;
        mul_a   = cx;
        mul_b   = HASH_MUL_X;
        state_d = ST_HB;
      end
      ST_HB: begin
        hash_d  = seed_q + prod_q[31:0];
        mul_en  = 1'b1;
        mul_a   = cy;
        mul_b   = HASH_MUL_Y;
        state_d = ST_HC;
      end
      ST_HC: begin
        hash_d  = hsum ^ 32'($signed(hsum) >>> 13);
        state_d = ST_HD;
      end
      ST_HD: begin
        mul_en  = 1'b1;
        mul_a   = hash_q;
        mul_b   = HASH_MUL_MIX;
        c_d     = c_q + 2'd1;
        state_d = (c_q == 2'd3) ? ST_L0 : ST_HA;
      end
      ST_L0: begin
        corner_d[3] = cval;
        mul_en      = 1'b1;
        mul_a       = 32'(corner_q[0]);
        mul_b       = 32'(inv_fx);
        state_d     = ST_L1;
      end
      ST_L1: begin
        lsum_d  = prod_q[31:0];
        mul_en  = 1'b1;
        mul_a   = 32'(corner_q[1]);
        mul_b   = 32'(fx_q);
        state_d = ST_L2;
      end
      ST_L2: begin
        row0_d  = lerp_sum[31:16];
        mul_en  = 1'b1;
        mul_a   = 32'(corner_q[2]);
        mul_b   = 32'(inv_fx);
        state_d = ST_L3;
      end
      ST_L3: begin
        lsum_d  = prod_q[31:0];
        mul_en  = 1'b1;
        mul_a   = 32'(corner_q[3]);
        mul_b   = 32'(fx_q);
        state_d = ST_L4;
      end
      ST_L4: begin
        row1_d  = lerp_sum[31:16];
        mul_en  = 1'b1;
        mul_a   = 32'(row0_q);
        mul_b   = 32'(inv_fy);
        state_d = ST_L5;
      end
      ST_L5: begin
        lsum_d  = prod_q[31:0];
        mul_en  = 1'b1;
        mul_a   = 32'(row1_q);
        mul_b   = 32'(fy_q);
        state_d = ST_L6;
      end
      ST_L6: begin
        vo_d    = lerp_sum[31:16];
        state_d = ST_L7;
      end
      ST_L7: begin
        // Horner form: doubling the running sum gives each later octave half the weight of the one before.
        acc_d   = (acc_q << 1) + ACC_W'(vo_q);
        sx_d    = sx_q << 1;
        sy_d    = sy_q << 1;
        oct_d   = oct_q + NW'(1);
        state_d = (oct_q == n_q - NW'(1)) ? ST_N0 : ST_SMX0;
      end
      ST_N0: begin
        mul_en  = 1'b1;
        mul_a   = 32'(acc_q);
        mul_b   = 32'(RECIP_TAB[5'(n_q)]);
        state_d = ST_N1;
      end
      ST_N1: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_data_d  = (|prod_q[63:RECIP_SHIFT+16]) ? '1 : prod_q[RECIP_SHIFT +: 16];
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign prod_d = 64'(mul_a) * 64'(mul_b);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      seed_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_i.valid) begin
        seed_q <= cfg_i.seed;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    sx_q       <= sx_d;
    sy_q       <= sy_d;
    n_q        <= n_d;
    oct_q      <= oct_d;
    c_q        <= c_d;
    acc_q      <= acc_d;
    fx_q       <= fx_d;
    fy_q       <= fy_d;
    hash_q     <= hash_d;
    lsum_q     <= lsum_d;
    row0_q     <= row0_d;
    row1_q     <= row1_d;
    vo_q       <= vo_d;
    corner_q   <= corner_d;
    if (mul_en) begin
      prod_q <= prod_d;
    end
  end

endmodule

FILE: test/tb_fractal_value_noise_2d.sv
module tb_fractal_value_noise_2d;
  import fvn_pkg::*;

  localparam int unsigned OCT_LIMIT   = DEF_MAX_OCTAVES;
  localparam int unsigned STALL_LIMIT = 6000;
  localparam int unsigned DRAIN_WAIT  = 28 * DEF_MAX_OCTAVES + 20;

  typedef struct {
    logic signed [POINT_W-1:0] x;
    logic signed [POINT_W-1:0] y;
    logic [OCT_W-1:0]          oct;
  } probe_t;

  logic clk_i;
  logic rst_ni;

  fvn_cfg_if cfg_bus ();
  fvn_in_if  point_bus ();
  fvn_out_if noise_bus ();

  fractal_value_noise_2d DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_bus),
    .in_i   (point_bus),
    .out_o  (noise_bus)
  );

  probe_t               probe_q[$];
  logic [NOISE_W-1:0]   noise_q[$];
  logic [SEED_W-1:0]    seed_now;
  int                   errors;
  int                   points_in;
  int                   noise_out;
  int                   seed_writes;
  int                   stall_cnt;
  int                   in_gap;
  int                   out_gap;
  logic                 in_fire;
  bit                   quiet;
  bit                   hold_out;
  bit [15:0]            oct_seen;

  function automatic logic [15:0] lattice_value(logic [31:0] ix, logic [31:0] iy,
                                                logic [31:0] sd);
    logic [31:0] h;
    h = sd + ix * 32'd374761393 + iy * 32'd668265263;
    h = (h ^ {{13{h[31]}}, h[31:13]}) * 32'd1274126177;
    h = h ^ {{16{h[31]}}, h[31:16]};
    return h[30:15];
  endfunction

  function automatic logic [31:0] ease(logic [15:0] f);
    logic [63:0] ff;
    logic [63:0] t;
    ff = 64'(f) * 64'(f);
    t  = (ff * (64'd196608 - 64'd2 * 64'(f))) >> 32;
    return t[31:0];
  endfunction

  function automatic logic [15:0] blend(logic [15:0] a, logic [15:0] b, logic [31:0] s);
    logic [63:0] t;
    t = 64'(a) * (64'd65536 - 64'(s)) + 64'(b) * 64'(s);
    return t[31:16];
  endfunction

  function automatic logic [NOISE_W-1:0] fbm_noise(logic signed [POINT_W-1:0] px,
                                                   logic signed [POINT_W-1:0] py,
                                                   logic [OCT_W-1:0] oct,
                                                   logic [SEED_W-1:0] sd);
    logic signed [63:0] ex;
    logic signed [63:0] ey;
    logic [63:0]        sx;
    logic [63:0]        sy;
    logic [63:0]        acc;
    logic [63:0]        span;
    logic [63:0]        recip;
    logic [63:0]        res;
    logic [31:0]        ix;
    logic [31:0]        iy;
    logic [31:0]        wx;
    logic [31:0]        wy;
    logic [15:0]        v;
    int                 n;
    ex  = px;
    ey  = py;
    n   = (oct == 0) ? 1 : ((oct > OCT_LIMIT) ? OCT_LIMIT : oct);
    acc = '0;
    for (int o = 0; o < n; o++) begin
      sx = ex << o;
      sy = ey << o;
      ix = sx[47:16];
      iy = sy[47:16];
      wx = ease(sx[15:0]);
      wy = ease(sy[15:0]);
      v  = blend(blend(lattice_value(ix, iy, sd), lattice_value(ix + 1, iy, sd), wx),
                 blend(lattice_value(ix, iy + 1, sd), lattice_value(ix + 1, iy + 1, sd), wx),
                 wy);
      acc = acc + (64'(v) << (n - 1 - o));
    end
    span  = (64'd1 << n) - 1;
    recip = ((64'd1 << 25) + span) / (64'd2 * span);
    res   = (acc * recip) >> 24;
    if (res > 64'd65535) begin
      res = 64'd65535;
    end
    return res[NOISE_W-1:0];
  endfunction

  initial begin
    clk_i = 1'b0;
  end

  always begin
    #2 clk_i = ~clk_i;
  end

  // Acceptance of points and noise beats, with prediction and comparison.
  always @(posedge clk_i) begin
    logic [NOISE_W-1:0] want;
    in_fire <= rst_ni && point_bus.valid && point_bus.ready;
    if (rst_ni && point_bus.valid && point_bus.ready) begin
      noise_q.push_back(fbm_noise(point_bus.point_x, point_bus.point_y,
                                  point_bus.octave_count, seed_now));
      oct_seen[point_bus.octave_count] = 1'b1;
      points_in++;
    end
    if (rst_ni && noise_bus.valid && noise_bus.ready) begin
      noise_out++;
      if (noise_q.size() == 0) begin
        $error("noise_value beat with nothing expected: actual %0d", noise_bus.noise_value);
        errors++;
      end else begin
        want = noise_q.pop_front();
        if (noise_bus.noise_value !== want) begin
          $error("noise_value mismatch: expected %0d, actual %0d", want,
                 noise_bus.noise_value);
          errors++;
        end
      end
    end
  end

  always @(negedge clk_i) begin
    probe_t p;
    if (rst_ni && (in_fire || !point_bus.valid)) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        point_bus.valid <= 1'b0;
      end else if (probe_q.size() != 0) begin
        if (!quiet && $urandom_range(0, 9) == 0) begin
          in_gap <= $urandom_range(0, 10);
          point_bus.valid <= 1'b0;
        end else begin
          p = probe_q.pop_front();
          point_bus.valid        <= 1'b1;
          point_bus.point_x      <= p.x;
          point_bus.point_y      <= p.y;
          point_bus.octave_count <= p.oct;
        end
      end else begin
        point_bus.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_out) begin
        noise_bus.ready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        noise_bus.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_gap <= $urandom_range(0, 10);
        noise_bus.ready <= 1'b0;
      end else begin
        noise_bus.ready <= 1'b1;
      end
    end
  end

  // Long receiver hold-off so that the block backs up and stalls its input.
  initial begin
    hold_out = 1'b0;
    wait (points_in >= 120);
    @(negedge clk_i);
    hold_out = 1'b1;
    repeat (1200) @(posedge clk_i);
    hold_out = 1'b0;
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (point_bus.valid && point_bus.ready) || (noise_bus.valid && noise_bus.ready)
        || (cfg_bus.valid && cfg_bus.ready)) begin
      stall_cnt <= 0;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
    if (stall_cnt == STALL_LIMIT) begin
      $display("tb_fractal_value_noise_2d: errors");
      $finish;
    end
  end

  task automatic add_probe(logic signed [POINT_W-1:0] x, logic signed [POINT_W-1:0] y,
                           logic [OCT_W-1:0] oct);
    probe_t p;
    p.x   = x;
    p.y   = y;
    p.oct = oct;
    probe_q.push_back(p);
  endtask

  function automatic logic [POINT_W-1:0] random_coord();
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return r[POINT_W-1:0];
      5, 6, 7:       return {{20{r[19]}}, r[19:0]};
      8:             return {r[39:16], r[0] ? 16'hFFFF : 16'h0000};
      default:       return {r[0] ? 2'b01 : 2'b10, r[37:0]};
    endcase
  endfunction

  task automatic settle();
    while (probe_q.size() != 0 || point_bus.valid || noise_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (3) @(negedge clk_i);
  endtask

  task automatic run_batch(int count);
    logic [OCT_W-1:0] oct;
    for (int i = 0; i < count; i++) begin
      oct = ($urandom_range(0, 9) < 8) ? OCT_W'($urandom_range(1, OCT_LIMIT))
                                       : OCT_W'($urandom_range(0, 15));
      add_probe(random_coord(), random_coord(), oct);
    end
    settle();
  endtask

  task automatic load_seed(logic [SEED_W-1:0] value);
    @(negedge clk_i);
    cfg_bus.valid <= 1'b1;
    cfg_bus.seed  <= value;
    do begin
      @(posedge clk_i);
    end while (!(cfg_bus.valid && cfg_bus.ready));
    seed_now = value;
    seed_writes++;
    @(negedge clk_i);
    cfg_bus.valid <= 1'b0;
  endtask

  initial begin
    errors      = 0;
    points_in   = 0;
    noise_out   = 0;
    seed_writes = 0;
    stall_cnt   = 0;
    in_gap      = 0;
    out_gap     = 0;
    in_fire     = 1'b0;
    quiet       = 1'b0;
    oct_seen    = '0;
    seed_now    = '0;
    rst_ni      = 1'b0;
    cfg_bus.valid          = 1'b0;
    cfg_bus.seed           = '0;
    point_bus.valid        = 1'b0;
    point_bus.point_x      = '0;
    point_bus.point_y      = '0;
    point_bus.octave_count = '0;
    noise_bus.ready        = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    add_probe(40'sh0, 40'sh0, 4'd1);
    add_probe(40'sh0, 40'sh0, 4'd0);
    add_probe(40'sh7F_FFFF_FFFF, 40'sh7F_FFFF_FFFF, 4'd8);
    add_probe(-40'sh80_0000_0000, -40'sh80_0000_0000, 4'd8);
    add_probe(-40'sd1, -40'sd1, 4'd1);
    add_probe(40'sh7F_FFFF_FFFF, -40'sh80_0000_0000, 4'd15);
    add_probe(-40'sh80_0000_0000, 40'sh7F_FFFF_FFFF, 4'd9);
    add_probe(40'sh00_0000_FFFF, 40'sh00_0000_FFFF, 4'd1);
    add_probe(40'sh00_0000_8000, 40'sh00_0001_0000, 4'd2);
    add_probe(40'sh00_FFFF_0000, 40'sh00_FFFF_FFFF, 4'd3);
    add_probe(40'sh7F_FFFF_0000, -40'sh80_0000_0000, 4'd4);
    add_probe(-40'sh00_0000_FFFF, 40'sh0, 4'd5);
    add_probe(40'sh55_5555_5555, 40'shAA_AAAA_AAAA, 4'd6);
    add_probe(40'shAA_AAAA_AAAA, 40'sh55_5555_5555, 4'd7);
    for (int o = 9; o <= 15; o++) begin
      add_probe((o % 2) ? -40'sd1 : 40'sh7F_FFFF_FFFF, 40'sh12_3456_789A, OCT_W'(o));
    end
    settle();

    load_seed(32'h7FFF_FFFF);
    run_batch(220);
    load_seed(32'h8000_0000);
    run_batch(220);
    load_seed(32'hFFFF_FFFF);
    run_batch(220);
    load_seed($urandom);
    run_batch(220);
    load_seed(32'h0000_0000);
    quiet = 1'b1;
    run_batch(270);

    repeat (DRAIN_WAIT) @(posedge clk_i);
    $display("Checked %0d noise beats from %0d points over %0d seed writes.",
             noise_out, points_in, seed_writes);
    $display("Octave counts driven (bit per count): %b.", oct_seen);
    if (errors == 0 && noise_q.size() == 0) begin
      $display("tb_fractal_value_noise_2d: clean");
    end else begin
      $display("tb_fractal_value_noise_2d: errors");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/fvn_pkg.sv
hw/rtl/fvn_intf.sv
hw/rtl/fractal_value_noise_2d.sv
test/tb_fractal_value_noise_2d.sv
